// ----- rtl/itw_pkg.sv -----
package itw_pkg;

   // word codes
   localparam logic [4:0] WORD_ZERO     = 5'd0;
   localparam logic [4:0] WORD_TEN_BASE = 5'd18;
   localparam logic [4:0] WORD_HUNDRED  = 5'd28;
   localparam logic [4:0] WORD_THOUSAND = 5'd29;
   localparam logic [4:0] WORD_MILLION  = 5'd30;
   localparam logic [4:0] WORD_BILLION  = 5'd31;

   localparam int WORD_W  = 5;
   localparam int SLOTS   = 16;

   // scale factors
   localparam logic [30:0] BILLION = 31'd1000000000;
   localparam logic [29:0] MILLION = 30'd1000000;
   localparam logic [19:0] THOUSAND = 20'd1000;

   // reciprocals for exact division by constants:
   // q = (n * ceil(2^s / d)) >> s with s = width(n) + ceil(log2(d))
   localparam int MIL_SHIFT = 50;
   localparam longint unsigned MIL_RECIP =
      ((64'd1 << MIL_SHIFT) + 64'd999999) / 64'd1000000;
   localparam int THO_SHIFT = 30;
   localparam longint unsigned THO_RECIP =
      ((64'd1 << THO_SHIFT) + 64'd999) / 64'd1000;

   // value split into its groups of three digits
   typedef struct packed {
      logic       zero;
      logic [1:0] bil;
      logic [9:0] mil;
      logic [9:0] tho;
      logic [9:0] rem;
   } itw_groups_type;

   // token slots in speaking order, with a mask of the ones in use
   typedef struct packed {
      logic [SLOTS-1:0]             mask;
      logic [SLOTS-1:0][WORD_W-1:0] words;
   } itw_slots_type;

   // hundreds digit of a group 0..999
   function automatic logic [3:0] hundreds_digit(input logic [9:0] grp);
      logic [3:0] h;
      h = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if (grp >= 10'(k * 100)) h = 4'(k);
      end
      return h;
   endfunction

   // tens digit of a remainder 0..99
   function automatic logic [3:0] tens_digit(input logic [6:0] rest);
      logic [3:0] t;
      t = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if (rest >= 7'(k * 10)) t = 4'(k);
      end
      return t;
   endfunction

endpackage

// ----- rtl/itw_split.sv -----
module itw_split (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [30:0]            in_value,
   output logic                   out_valid,
   input  logic                   out_ready,
   output itw_pkg::itw_groups_type out_groups
);
   import itw_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   logic        zero1_ff, zero2_ff, zero3_ff, zero4_ff;
   logic [1:0]  bil1_ff, bil2_ff, bil3_ff, bil4_ff;
   logic [29:0] r1_ff, r2_ff;
   logic [9:0]  mil2_ff, mil3_ff, mil4_ff;
   logic [19:0] r3_ff, r4_ff;
   logic [9:0]  tho4_ff;
   itw_groups_type grp5_ff;

   logic [1:0]  bil1_in;
   logic [29:0] r1_in;
   logic [60:0] mil_prod;
   logic [29:0] r3_wide;
   logic [40:0] tho_prod;
   logic [19:0] rem_wide;

   function automatic logic [29:0] mil3_in_fn(input logic [9:0] m);
      return 30'(m) * MILLION;
   endfunction

   // ready chain: a stage moves when it is empty or its successor moves
   assign rdy5     = !v5_ff || out_ready;
   assign rdy4     = !v4_ff || rdy5;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // stage 1: billions by compare, remainder below one billion
   always_comb begin
      if (in_value >= 31'(2) * BILLION) begin
         bil1_in = 2'd2;
         r1_in   = 30'(in_value - 31'(2) * BILLION);
      end else if (in_value >= BILLION) begin
         bil1_in = 2'd1;
         r1_in   = 30'(in_value - BILLION);
      end else begin
         bil1_in = 2'd0;
         r1_in   = in_value[29:0];
      end
   end

   // stage 2: millions by reciprocal multiply
   assign mil_prod = 61'(r1_ff) * 61'(MIL_RECIP);
   // stage 3: remainder below one million
   assign r3_wide  = r2_ff - 30'(mil3_in_fn(mil2_ff));
   // stage 4: thousands by reciprocal multiply
   assign tho_prod = 41'(r3_ff) * 41'(THO_RECIP);
   // stage 5: remainder below one thousand
   assign rem_wide = r4_ff - 20'(tho4_ff) * THOUSAND;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         zero1_ff <= (in_value == '0);
         bil1_ff  <= bil1_in;
         r1_ff    <= r1_in;
      end
      if (rdy2) begin
         zero2_ff <= zero1_ff;
         bil2_ff  <= bil1_ff;
         r2_ff    <= r1_ff;
         mil2_ff  <= mil_prod[MIL_SHIFT+9:MIL_SHIFT];
      end
      if (rdy3) begin
         zero3_ff <= zero2_ff;
         bil3_ff  <= bil2_ff;
         mil3_ff  <= mil2_ff;
         r3_ff    <= r3_wide[19:0];
      end
      if (rdy4) begin
         zero4_ff <= zero3_ff;
         bil4_ff  <= bil3_ff;
         mil4_ff  <= mil3_ff;
         r4_ff    <= r3_ff;
         tho4_ff  <= tho_prod[THO_SHIFT+9:THO_SHIFT];
      end
      if (rdy5) begin
         grp5_ff.zero <= zero4_ff;
         grp5_ff.bil  <= bil4_ff;
         grp5_ff.mil  <= mil4_ff;
         grp5_ff.tho  <= tho4_ff;
         grp5_ff.rem  <= rem_wide[9:0];
      end
   end

   assign out_valid  = v5_ff;
   assign out_groups = grp5_ff;

endmodule

// ----- rtl/itw_digits.sv -----
module itw_digits (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  itw_pkg::itw_groups_type in_groups,
   output logic                    out_valid,
   input  logic                    out_ready,
   output itw_pkg::itw_slots_type  out_slots
);
   import itw_pkg::*;

   // one group of three digits, split into hundreds and the rest
   typedef struct packed {
      logic       nz;
      logic [3:0] hund;
      logic [6:0] rest;
   } split_type;

   // tokens of one group before its scale word
   typedef struct packed {
      logic [3:0]             mask;
      logic [3:0][WORD_W-1:0] words;
   } group_tokens_type;

   logic v6_ff, v7_ff;
   logic rdy6, rdy7;

   logic       zero6_ff;
   logic [1:0] bil6_ff;
   split_type  mil6_ff, tho6_ff, rem6_ff;
   split_type  mil6_in, tho6_in, rem6_in;
   itw_slots_type slots7_ff, slots7_in;
   group_tokens_type mil_tok, tho_tok, rem_tok;

   assign rdy7     = !v7_ff || out_ready;
   assign rdy6     = !v6_ff || rdy7;
   assign in_ready = rdy6;

   function automatic split_type split_group(input logic [9:0] grp);
      split_type s;
      logic [9:0] r;
      s.nz   = (grp != '0);
      s.hund = hundreds_digit(grp);
      r      = grp - 10'(s.hund) * 10'd100;
      s.rest = r[6:0];
      return s;
   endfunction

   function automatic group_tokens_type group_tokens(input split_type s);
      group_tokens_type g;
      logic [3:0] tens;
      logic [6:0] units;
      tens     = tens_digit(s.rest);
      units    = s.rest - 7'(tens) * 7'd10;
      g.mask   = '0;
      g.words  = '0;
      // hundreds word and Hundred
      g.words[0] = 5'(s.hund);
      g.words[1] = WORD_HUNDRED;
      if (s.hund != '0) g.mask[1:0] = 2'b11;
      // teens or tens word, then units
      if (s.rest < 7'd20) begin
         g.words[2] = 5'(s.rest);
         g.mask[2]  = (s.rest != '0);
      end else begin
         g.words[2] = WORD_TEN_BASE + 5'(tens);
         g.mask[2]  = 1'b1;
         g.words[3] = 5'(units[3:0]);
         g.mask[3]  = (units != '0);
      end
      return g;
   endfunction

   // stage 6: hundreds digit and remainder of each group
   assign mil6_in = split_group(in_groups.mil);
   assign tho6_in = split_group(in_groups.tho);
   assign rem6_in = split_group(in_groups.rem);

   // stage 7: token slots in speaking order
   always_comb begin
      mil_tok = group_tokens(mil6_ff);
      tho_tok = group_tokens(tho6_ff);
      rem_tok = group_tokens(rem6_ff);

      // billions: one digit word and Billion
      slots7_in.words[0] = 5'(bil6_ff);
      slots7_in.words[1] = WORD_BILLION;
      slots7_in.mask[1:0] = (bil6_ff != '0) ? 2'b11 : 2'b00;

      slots7_in.words[5:2] = mil_tok.words;
      slots7_in.mask[5:2]  = mil_tok.mask;
      slots7_in.words[6]   = WORD_MILLION;
      slots7_in.mask[6]    = mil6_ff.nz;

      slots7_in.words[10:7] = tho_tok.words;
      slots7_in.mask[10:7]  = tho_tok.mask;
      slots7_in.words[11]   = WORD_THOUSAND;
      slots7_in.mask[11]    = tho6_ff.nz;

      slots7_in.words[15:12] = rem_tok.words;
      slots7_in.mask[15:12]  = rem_tok.mask;

      // a zero value gives the single word Zero
      if (zero6_ff) begin
         slots7_in.words[14] = WORD_ZERO;
         slots7_in.mask[14]  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (rdy6) v6_ff <= in_valid;
         if (rdy7) v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy6) begin
         zero6_ff <= in_groups.zero;
         bil6_ff  <= in_groups.bil;
         mil6_ff  <= mil6_in;
         tho6_ff  <= tho6_in;
         rem6_ff  <= rem6_in;
      end
      if (rdy7) slots7_ff <= slots7_in;
   end

   assign out_valid = v7_ff;
   assign out_slots = slots7_ff;

endmodule

// ----- rtl/itw_serial.sv -----
module itw_serial (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  itw_pkg::itw_slots_type in_slots,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [4:0]             out_word,
   output logic                   out_last
);
   import itw_pkg::*;

   logic [SLOTS-1:0]             mask_ff, mask_in;
   logic [SLOTS-1:0][WORD_W-1:0] words_ff;
   logic                         out_valid_ff, out_valid_in;
   logic [WORD_W-1:0]            out_word_ff;
   logic                         out_last_ff;

   logic [3:0]       idx;
   logic [SLOTS-1:0] rest_mask;
   logic             out_free, pop, load;

   // lowest slot still in use
   always_comb begin
      idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) idx = 4'(i);
      end
   end

   assign rest_mask = mask_ff & ~(SLOTS'(1) << idx);
   assign out_free  = !out_valid_ff || out_ready;
   assign pop       = (mask_ff != '0) && out_free;
   // take the next transaction once the current run is fully handed off
   assign in_ready  = (mask_ff == '0) || (pop && (rest_mask == '0));
   assign load      = in_valid && in_ready;

   always_comb begin
      mask_in = mask_ff;
      if (pop) mask_in = rest_mask;
      if (load) mask_in = in_slots.mask;
      out_valid_in = out_valid_ff;
      if (out_ready) out_valid_in = 1'b0;
      if (pop) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) words_ff <= in_slots.words;
      if (pop) begin
         out_word_ff <= words_ff[idx];
         out_last_ff <= (rest_mask == '0);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;
   assign out_last  = out_last_ff;

endmodule

// ----- rtl/integer_to_word_tokens_top.sv -----
// A value passes the split and digit stages, which hold up to 7 values, then
// the serializer's slot and word registers. Throughput: one word token per cycle
// unless rsp_ready stalls; a value has 1 to 16 tokens on the single output port
// of the token serializer, which loads the next value as it pops the last token.
// Reset (synchronous, active high) empties all stages and the serializer.
module integer_to_word_tokens_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [30:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_word,
   output logic        rsp_last
);
   import itw_pkg::*;

   logic           grp_valid, grp_ready;
   itw_groups_type groups;
   logic           slot_valid, slot_ready;
   itw_slots_type  slots;

   // value to groups of three digits
   itw_split u_split (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_value   (req_value),
      .out_valid  (grp_valid),
      .out_ready  (grp_ready),
      .out_groups (groups)
   );

   // groups to token slots
   itw_digits u_digits (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (grp_valid),
      .in_ready  (grp_ready),
      .in_groups (groups),
      .out_valid (slot_valid),
      .out_ready (slot_ready),
      .out_slots (slots)
   );

   // token slots to one word per transaction
   itw_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (slot_valid),
      .in_ready  (slot_ready),
      .in_slots  (slots),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (rsp_word),
      .out_last  (rsp_last)
   );

endmodule

// ----- tb/word_token_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the word token block, spells each accepted value
// into its expected token run and compares every accepted token in order.
module word_token_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [30:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [4:0]  rsp_word,
   input  logic        rsp_last,
   output int          fail_count,
   output int          tokens_pending
);
   import itw_pkg::*;

   typedef struct {
      logic [4:0] word;
      logic       last;
   } word_token_type;

   // tokens still owed by the block, oldest first
   word_token_type expected_tokens[$];
   // scratch run for the value being spelled
   logic [4:0]  spelled_words[$];

   // one group of three digits: hundreds, then tens/teens and units
   task automatic spell_group(input int unsigned grp);
      int unsigned hund;
      int unsigned rest;
      hund = grp / 100;
      rest = grp % 100;
      if (hund != 0) begin
         spelled_words.push_back(5'(hund));
         spelled_words.push_back(WORD_HUNDRED);
      end
      if (rest != 0) begin
         if (rest < 20) begin
            spelled_words.push_back(5'(rest));
         end else begin
            spelled_words.push_back(WORD_TEN_BASE + 5'(rest / 10));
            if (rest % 10 != 0) spelled_words.push_back(5'(rest % 10));
         end
      end
   endtask

   // full value: scale groups in speaking order, last token flagged
   task automatic spell_value(input logic [30:0] value);
      int unsigned v;
      int unsigned bil;
      int unsigned mil;
      int unsigned tho;
      int unsigned rem;
      word_token_type tok;
      v   = 32'(value);
      bil = v / 1000000000;
      mil = (v / 1000000) % 1000;
      tho = (v / 1000) % 1000;
      rem = v % 1000;
      spelled_words.delete();
      if (v == 0) begin
         spelled_words.push_back(WORD_ZERO);
      end else begin
         if (bil != 0) begin
            spell_group(bil);
            spelled_words.push_back(WORD_BILLION);
         end
         if (mil != 0) begin
            spell_group(mil);
            spelled_words.push_back(WORD_MILLION);
         end
         if (tho != 0) begin
            spell_group(tho);
            spelled_words.push_back(WORD_THOUSAND);
         end
         if (rem != 0) spell_group(rem);
      end
      foreach (spelled_words[k]) begin
         tok.word = spelled_words[k];
         tok.last = (k == spelled_words.size() - 1);
         expected_tokens.push_back(tok);
      end
   endtask

   // sample both channels at the edge where transactions complete
   always @(posedge clock) begin
      word_token_type exp_tok;
      if (!reset) begin
         if (req_valid && req_ready) spell_value(req_value);
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               $error("unexpected token: word %0d last %0b", rsp_word, rsp_last);
               fail_count++;
            end else begin
               exp_tok = expected_tokens.pop_front();
               if (rsp_word !== exp_tok.word) begin
                  $error("word: expected %0d, got %0d", exp_tok.word, rsp_word);
                  fail_count++;
               end
               if (rsp_last !== exp_tok.last) begin
                  $error("last: expected %0b, got %0b", exp_tok.last, rsp_last);
                  fail_count++;
               end
            end
         end
      end
      tokens_pending = expected_tokens.size();
   end

endmodule

// ----- tb/tb_integer_to_word_tokens_top.sv -----
`timescale 1ns / 1ps

module tb_integer_to_word_tokens_top;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [30:0] req_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [4:0]  rsp_word;
   logic        rsp_last;

   int fail_count;
   int tokens_pending;

   // long receiver hold-off handshake between the two driver processes
   bit hold_off_req = 1'b0;
   bit hold_done    = 1'b0;
   bit in_hold      = 1'b0;

   int values_sent = 0;

   localparam int NUM_RANDOM = 480;

   // extremes, teens, round tens, zero groups, full 16-token run
   int unsigned directed_values [0:24] = '{
      0, 1, 9, 10, 11, 13, 19, 20, 21, 45, 99, 100, 101, 110, 120, 999,
      1000, 1001, 20000, 1010010, 1000000, 1000000000, 2000000000,
      1777777777, 2147483647
   };

   integer_to_word_tokens_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .rsp_last  (rsp_last)
   );

   word_token_checker token_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word       (rsp_word),
      .rsp_last       (rsp_last),
      .fail_count     (fail_count),
      .tokens_pending (tokens_pending)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // one group of three digits, biased toward the interesting shapes
   function automatic int unsigned random_group();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return $urandom_range(1, 19);
         2: return 10 * $urandom_range(2, 9);
         3: return 100 * $urandom_range(1, 9);
         4: return 100 * $urandom_range(1, 9) + $urandom_range(1, 19);
         default: return $urandom_range(0, 999);
      endcase
   endfunction

   function automatic logic [30:0] random_value();
      int unsigned     r;
      longint unsigned total;
      r = $urandom_range(0, 9);
      if (r < 2) return 31'($urandom_range(0, 32'h7FFF_FFFF));
      if (r == 2) return 31'($urandom_range(0, 999));
      total = 64'($urandom_range(0, 2)) * 64'd1000000000
            + 64'(random_group()) * 64'd1000000
            + 64'(random_group()) * 64'd1000
            + 64'(random_group());
      if (total > 64'h7FFF_FFFF) total = total - 64'd1000000000;
      return 31'(total);
   endfunction

   // idle cycles after a transaction; none during the hold-off or quiet runs
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (in_hold || (values_sent / 64) % 3 == 1) return 0;
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_value(input logic [30:0] value);
      int gap;
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      values_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_value <= 31'($urandom());
         repeat (gap) @(posedge clock);
      end
   endtask

   // receiver: short and long stalls, quiet stretches, one long hold-off
   initial begin : rsp_side
      int stall_left;
      int cyc;
      int r;
      stall_left = 0;
      cyc        = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_off_req && !hold_done) begin
            hold_done = 1'b1;
            in_hold   = 1'b1;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            in_hold = 1'b0;
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ((cyc / 300) % 3 != 2) begin
               r = $urandom_range(0, 99);
               if (r < 12) stall_left = $urandom_range(1, 3);
               else if (r < 15) stall_left = $urandom_range(10, 50);
            end
         end
      end
   end

   // stimulus and verdict
   initial begin : req_side
      reset     = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_values[k]) send_value(31'(directed_values[k]));

      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == 150) hold_off_req = 1'b1;
         send_value(random_value());
      end
      req_valid <= 1'b0;

      // let the checker record the final transaction before draining
      @(posedge clock);
      wait (tokens_pending == 0);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #(8_000_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule
